// File: rtl/core/ntha_pkg.sv
// Shared types and constants of the nearest-target history averager.
// No dependencies; imported by every module of the block except ntha_ram.
package ntha_pkg;

  localparam int HIST_DEPTH = 10;
  localparam int COORD_W    = 32;
  localparam int LABEL_W    = 8;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SUM_W      = COORD_W + CNT_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int HIST_W     = 3 * COORD_W;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [LABEL_W-1:0] TARGET_LABEL_RST = LABEL_W'(1);

  typedef enum logic {
    REQ_OBJECT = 1'b0,
    REQ_QUERY  = 1'b1
  } req_kind_t;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PUSH_RD,
    BK_PUSH_WR,
    BK_DIV
  } back_state_t;

  typedef struct packed {
    logic                      req_type;
    logic [LABEL_W-1:0]        label;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      frame_last;
  } in_item_t;

  typedef struct packed {
    logic                      success;
    logic signed [COORD_W-1:0] avg_x;
    logic signed [COORD_W-1:0] avg_y;
    logic signed [COORD_W-1:0] avg_z;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_stat_t;

endpackage

// File: rtl/core/ntha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ntha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/ntha_front.sv
// Front end: takes items, tracks the nearest target of the open frame and
// queues push and query commands. Depends on ntha_pkg.
module ntha_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  ntha_pkg::in_item_t               in_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ntha_pkg::LABEL_W-1:0]     cfg_data,
  input  ntha_pkg::cmdq_stat_t             q_stat,
  output logic                             q_wr,
  output ntha_pkg::cmd_t                   q_wdata
);
  import ntha_pkg::*;

  logic [LABEL_W-1:0]        label_r;
  logic                      best_valid_r, best_valid_nxt;
  logic signed [COORD_W-1:0] best_x_r, best_x_nxt;
  logic signed [COORD_W-1:0] best_y_r, best_y_nxt;
  logic signed [COORD_W-1:0] best_z_r, best_z_nxt;
  logic                      accept;
  logic                      is_query;
  logic                      take;

  assign cfg_ready = 1'b1;
  assign full      = q_stat.full;
  assign accept    = push && !q_stat.full;
  assign is_query  = (in_data.req_type == REQ_QUERY);

  always_comb begin
    take = (in_data.label == label_r) &&
           (!best_valid_r || (in_data.pos_z < best_z_r));
    best_x_nxt = take ? in_data.pos_x : best_x_r;
    best_y_nxt = take ? in_data.pos_y : best_y_r;
    best_z_nxt = take ? in_data.pos_z : best_z_r;
    best_valid_nxt = in_data.frame_last ? 1'b0 : (best_valid_r || take);
    q_wr = accept && (is_query || (in_data.frame_last && (best_valid_r || take)));
    q_wdata.kind = is_query ? CMD_QUERY : CMD_PUSH;
    q_wdata.x    = best_x_nxt;
    q_wdata.y    = best_y_nxt;
    q_wdata.z    = best_z_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r      <= TARGET_LABEL_RST;
      best_valid_r <= 1'b0;
      best_x_r     <= '0;
      best_y_r     <= '0;
      best_z_r     <= '0;
    end else begin
      if (cfg_valid) begin
        label_r <= cfg_data;
      end
      if (accept && !is_query) begin
        best_valid_r <= best_valid_nxt;
        best_x_r     <= best_x_nxt;
        best_y_r     <= best_y_nxt;
        best_z_r     <= best_z_nxt;
      end
    end
  end

endmodule

// File: rtl/core/ntha_cmdq.sv
// Short command queue between front and back end.
// Depends on ntha_pkg.
module ntha_cmdq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  ntha_pkg::cmd_t       wdata,
  input  logic                 rd,
  output ntha_pkg::cmd_t       rdata,
  output ntha_pkg::cmdq_stat_t stat
);
  import ntha_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign stat.full  = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (rd) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W + 1)'(wr) - (QPTR_W + 1)'(rd);
    end
  end

endmodule

// File: rtl/core/ntha_back.sv
// Back end: ring history with running sums, and a bit-serial divider that
// averages the sums on a query. Depends on ntha_pkg and ntha_ram.
module ntha_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ntha_pkg::cmdq_stat_t q_stat,
  input  ntha_pkg::cmd_t       q_rdata,
  output logic                 q_rd,
  output logic                 empty,
  input  logic                 pop,
  output ntha_pkg::out_item_t  out_data
);
  import ntha_pkg::*;

  back_state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]          slot_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SUM_W-1:0]    sum_r [3];
  logic signed [SUM_W-1:0]    sum_nxt [3];
  cmd_t                       cur_r;
  logic                       neg_r [3];
  logic [CNT_W-1:0]           rem_r [3];
  logic [CNT_W-1:0]           rem_nxt [3];
  logic [SUM_W-1:0]           quo_r [3];
  logic [SUM_W-1:0]           quo_nxt [3];
  logic [SUM_W-1:0]           res [3];
  logic [DIV_CNT_W-1:0]       dcnt_r;
  logic                       out_valid_r;
  out_item_t                  out_data_r;
  logic                       ram_we;
  logic [HIST_W-1:0]          ram_rdata;
  logic signed [COORD_W-1:0]  new_c [3];
  logic signed [COORD_W-1:0]  old_c [3];
  logic                       hist_full;
  logic                       div_start;
  logic                       div_done;
  logic                       zero_query;
  logic [CNT_W:0]             trial [3];
  logic                       ge [3];

  ntha_ram #(
    .WIDTH(HIST_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata({cur_r.x, cur_r.y, cur_r.z}),
    .raddr(slot_r),
    .rdata(ram_rdata)
  );

  assign hist_full = (cnt_r == CNT_W'(HIST_DEPTH));
  assign new_c[0]  = cur_r.x;
  assign new_c[1]  = cur_r.y;
  assign new_c[2]  = cur_r.z;
  assign old_c[0]  = ram_rdata[3*COORD_W-1:2*COORD_W];
  assign old_c[1]  = ram_rdata[2*COORD_W-1:COORD_W];
  assign old_c[2]  = ram_rdata[COORD_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_rd) begin
          if (q_rdata.kind == CMD_PUSH) begin
            state_nxt = BK_PUSH_RD;
          end else if (cnt_r != '0) begin
            state_nxt = BK_DIV;
          end
        end
      end
      BK_PUSH_RD: state_nxt = BK_PUSH_WR;
      BK_PUSH_WR: state_nxt = BK_IDLE;
      BK_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_rd       = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    zero_query = 1'b0;
    div_done   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_rd = !q_stat.empty && ((q_rdata.kind == CMD_PUSH) || !out_valid_r);
        div_start  = q_rd && (q_rdata.kind == CMD_QUERY) && (cnt_r != '0);
        zero_query = q_rd && (q_rdata.kind == CMD_QUERY) && (cnt_r == '0);
      end
      BK_PUSH_WR: ram_we = 1'b1;
      BK_DIV:     div_done = (dcnt_r == '0);
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = sum_r[i] + SUM_W'(new_c[i]) - (hist_full ? SUM_W'(old_c[i]) : '0);
      trial[i]   = {rem_r[i], quo_r[i][SUM_W-1]};
      ge[i]      = (trial[i] >= {1'b0, cnt_r});
      rem_nxt[i] = ge[i] ? CNT_W'(trial[i] - {1'b0, cnt_r}) : trial[i][CNT_W-1:0];
      quo_nxt[i] = {quo_r[i][SUM_W-2:0], ge[i]};
      res[i]     = neg_r[i] ? (~quo_nxt[i] + 1'b1) : quo_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      slot_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= sum_nxt[i];
        end
        slot_r <= (slot_r == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (!hist_full) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (zero_query || div_done) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_rdata;
    end
    if (div_start) begin
      dcnt_r <= DIV_CNT_W'(SUM_W - 1);
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= sum_r[i][SUM_W-1];
        rem_r[i] <= '0;
        quo_r[i] <= sum_r[i][SUM_W-1] ? SUM_W'(-sum_r[i]) : SUM_W'(sum_r[i]);
      end
    end else if (state_r == BK_DIV) begin
      dcnt_r <= dcnt_r - 1'b1;
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
      end
    end
    if (zero_query) begin
      out_data_r <= '0;
    end else if (div_done) begin
      out_data_r.success <= 1'b1;
      out_data_r.avg_x   <= res[0][COORD_W-1:0];
      out_data_r.avg_y   <= res[1][COORD_W-1:0];
      out_data_r.avg_z   <= res[2][COORD_W-1:0];
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HIST_DEPTH))
    else $error("history count above depth");

  a_slot_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !hist_full |-> (CNT_W'(slot_r) == cnt_r))
    else $error("write slot out of step with count before wrap");

  a_div_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> !out_valid_r)
    else $error("divider running while result register holds an item");

  a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0))
    else $error("nonzero sums with empty history");

endmodule

// File: rtl/core/nearest_target_history_average_top.sv
// Top level of the nearest-target history averager.
// Depends on ntha_pkg, ntha_front, ntha_cmdq, ntha_back.
//
// Objects are taken one per cycle while the command queue has room; the
// front end keeps the nearest object of the configured label per frame and
// on the frame's last object queues a push if one was kept. A push passes
// through the back end's dequeue, history RAM read, and sum update and write
// steps. A query on an empty history returns failure in the cycle after it is
// dequeued; otherwise the averages come from a bit-serial divider, one
// quotient bit per cycle over the 36-bit sums. A query also waits for the
// result register to be popped. target_label may be written at any cycle;
// cfg_ready is always high.
module nearest_target_history_average_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  ntha_pkg::in_item_t           in_data,
  output logic                         empty,
  input  logic                         pop,
  output ntha_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ntha_pkg::LABEL_W-1:0] cfg_data
);
  import ntha_pkg::*;

  cmdq_stat_t q_stat;
  logic       q_wr;
  logic       q_rd;
  cmd_t       q_wdata;
  cmd_t       q_rdata;

  ntha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata)
  );

  ntha_cmdq u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (q_wr),
    .wdata(q_wdata),
    .rd   (q_rd),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  ntha_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .q_rdata (q_rdata),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_target_history_average_top.
// Depends on ntha_pkg and the block's RTL; predicts the history averages in SV.
module testbench;
  import ntha_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 64;
  localparam int COORD_MAX     = 32'sh7fff_ffff;
  localparam int COORD_MIN     = int'(32'h8000_0000);
  localparam int IN_W          = $bits(in_item_t);

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                push      = 1'b0;
  logic                full;
  in_item_t            in_data   = '0;
  logic                empty;
  logic                pop       = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LABEL_W-1:0]  cfg_data  = '0;

  bit                  quiet        = 1'b0;
  int                  pop_hold     = 0;
  int                  idle_cycles  = 0;
  int                  mismatch_count = 0;
  int                  result_index = 0;

  // predicted state of the block
  logic [LABEL_W-1:0]  model_label = TARGET_LABEL_RST;
  bit                  cand_valid  = 1'b0;
  int                  cand_x = 0, cand_y = 0, cand_z = 0;
  int                  hist_x[HIST_DEPTH];
  int                  hist_y[HIST_DEPTH];
  int                  hist_z[HIST_DEPTH];
  int                  hist_slot  = 0;
  int                  hist_count = 0;
  longint              sum_x = 0, sum_y = 0, sum_z = 0;
  out_item_t           expected_averages[$];
  out_item_t           want_avg;

  nearest_target_history_average_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void track_item(input in_item_t item);
    out_item_t avg;
    int z;
    avg = '0;
    z   = item.pos_z;
    if (item.req_type == REQ_QUERY) begin
      if (hist_count != 0) begin
        avg.success = 1'b1;
        avg.avg_x   = 32'(sum_x / hist_count);
        avg.avg_y   = 32'(sum_y / hist_count);
        avg.avg_z   = 32'(sum_z / hist_count);
      end
      expected_averages = {expected_averages, avg};
    end else begin
      if (item.label == model_label && (!cand_valid || z < cand_z)) begin
        cand_valid = 1'b1;
        cand_x = item.pos_x;
        cand_y = item.pos_y;
        cand_z = z;
      end
      if (item.frame_last) begin
        if (cand_valid) begin
          if (hist_count == HIST_DEPTH) begin
            sum_x -= hist_x[hist_slot];
            sum_y -= hist_y[hist_slot];
            sum_z -= hist_z[hist_slot];
          end else begin
            hist_count++;
          end
          hist_x[hist_slot] = cand_x;
          hist_y[hist_slot] = cand_y;
          hist_z[hist_slot] = cand_z;
          sum_x += cand_x;
          sum_y += cand_y;
          sum_z += cand_z;
          hist_slot = (hist_slot + 1) % HIST_DEPTH;
        end
        cand_valid = 1'b0;
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: result %0d %s mismatch, want %h got %h", $time, result_index, field,
             want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (cfg_valid && cfg_ready) begin
        model_label = cfg_data;
      end
      if (pop && !empty) begin
        if (expected_averages.size() == 0) begin
          report_mismatch("unexpected", '0, out_data.avg_x);
        end else begin
          want_avg = expected_averages[0];
          expected_averages.delete(0);
          if (out_data.success !== want_avg.success)
            report_mismatch("success", 32'(want_avg.success), 32'(out_data.success));
          if (out_data.avg_x !== want_avg.avg_x)
            report_mismatch("avg_x", want_avg.avg_x, out_data.avg_x);
          if (out_data.avg_y !== want_avg.avg_y)
            report_mismatch("avg_y", want_avg.avg_y, out_data.avg_y);
          if (out_data.avg_z !== want_avg.avg_z)
            report_mismatch("avg_z", want_avg.avg_z, out_data.avg_z);
        end
        result_index++;
      end
      if (push && !full) begin
        track_item(in_data);
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without an item", idle_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side: random stall bursts, always ready once quiet
  always @(negedge clk) begin
    if (!rst_n) begin
      pop = 1'b0;
    end else if (quiet) begin
      pop = 1'b1;
    end else if (pop_hold != 0) begin
      pop_hold--;
    end else if ($urandom_range(0, 3) == 0) begin
      pop      = 1'b0;
      pop_hold = $urandom_range(0, 11);
    end else begin
      pop      = 1'b1;
      pop_hold = $urandom_range(0, 19);
    end
  end

  function automatic in_item_t make_obj(input logic [7:0] label, input int x, input int y,
                                        input int z, input bit last);
    in_item_t item;
    item            = '0;
    item.req_type   = REQ_OBJECT;
    item.label      = label;
    item.pos_x      = x;
    item.pos_y      = y;
    item.pos_z      = z;
    item.frame_last = last;
    return item;
  endfunction

  function automatic in_item_t make_query();
    in_item_t item;
    item          = IN_W'({$urandom, $urandom, $urandom, $urandom});
    item.req_type = REQ_QUERY;
    return item;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3:    return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_random_obj(input logic [7:0] target, input bit last);
    logic [7:0] label;
    label = ($urandom_range(0, 99) < 65) ? target : 8'($urandom_range(0, 255));
    return make_obj(label, pick_coord(), pick_coord(), pick_coord(), last);
  endfunction

  task automatic send_item(input in_item_t item);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    push    = 1'b1;
    in_data = item;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    push = 1'b0;
    while (expected_averages.size() != 0) @(negedge clk);
  endtask

  task automatic write_label(input logic [LABEL_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_empty_history();
    send_item(make_query());
  endtask

  // tie keeps the first, other labels ignored, non-target last item closes the frame
  task automatic test_nearest_choice();
    send_item(make_obj(8'd1, 100, 200, 5, 1'b0));
    send_item(make_obj(8'd1, 300, 400, 5, 1'b0));
    send_item(make_obj(8'd2, 7, 7, COORD_MIN, 1'b0));
    send_item(make_obj(8'd9, 8, 8, COORD_MIN, 1'b1));
    send_item(make_query());
  endtask

  // frame without target, query inside an open frame, farther target not taken
  task automatic test_frame_edges();
    send_item(make_obj(8'd0, 1, 2, 3, 1'b1));
    send_item(make_query());
    send_item(make_obj(8'd1, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0));
    send_item(make_query());
    send_item(make_obj(8'd1, 1, 1, COORD_MAX, 1'b1));
    send_item(make_query());
    drain_results();
  endtask

  task automatic test_history_wrap();
    write_label(8'hFF);
    for (int i = 0; i <= HIST_DEPTH; i++) begin
      send_item(make_obj(8'hFF, COORD_MAX, COORD_MIN, (i % 2) ? COORD_MAX : COORD_MIN,
                         1'b1));
    end
    send_item(make_query());
  endtask

  task automatic test_random_traffic(input logic [7:0] target, input int n_items);
    int sent;
    int pick;
    int frame_len;
    sent = 0;
    write_label(target);
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 2 && !quiet) begin
        drain_results();
      end else if (pick < 15) begin
        send_item(in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom})));
        sent++;
      end else if (pick < 40) begin
        send_item(make_query());
        sent++;
      end else begin
        frame_len = $urandom_range(1, 6);
        for (int i = 0; i < frame_len; i++) begin
          send_item(make_random_obj(target, i == frame_len - 1));
        end
        sent += frame_len;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_history();
    test_nearest_choice();
    test_frame_edges();
    test_history_wrap();
    test_random_traffic(8'h00, 240);
    test_random_traffic(8'hFF, 240);
    test_random_traffic(8'($urandom_range(0, 255)), 240);
    test_random_traffic(8'h01, 240);
    quiet = 1'b1;
    test_random_traffic(8'($urandom_range(0, 255)), 240);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_averages.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
